### hdl/irft_pkg.sv
// Shared constants, types and helpers for the infrared frame transmitter.
package irft_pkg;

  localparam int CodeBits = 32;
  localparam int BitCntW  = $clog2(CodeBits + 1);
  localparam int PeriodW  = 16;
  localparam int HalfW    = 8;
  localparam int CodeW    = 32;

  typedef enum logic [2:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_STOP_SPACE   = 3'd5,
    REG_CARRIER_HALF = 3'd6
  } reg_index_t;

  localparam logic [PeriodW-1:0] LeaderMarkReset  = 16'd9000;
  localparam logic [PeriodW-1:0] LeaderSpaceReset = 16'd4500;
  localparam logic [PeriodW-1:0] BitMarkReset     = 16'd560;
  localparam logic [PeriodW-1:0] OneSpaceReset    = 16'd560;
  localparam logic [PeriodW-1:0] ZeroSpaceReset   = 16'd1690;
  localparam logic [PeriodW-1:0] StopSpaceReset   = 16'd5000;
  localparam logic [HalfW-1:0]   CarrierHalfReset = 8'd13;

  localparam logic FuncTick  = 1'b0;
  localparam logic FuncStart = 1'b1;

  typedef struct packed {
    logic ir_out;
    logic mark_active;
    logic busy_res;
    logic frame_done;
    logic start_ignored;
  } result_t;

  // A programmed length of zero still lasts one tick.
  function automatic logic [PeriodW-1:0] period_len(input logic [PeriodW-1:0] len);
    period_len = (len == '0) ? PeriodW'(1) : len;
  endfunction

endpackage

### hdl/irft_if.sv
// Valid/ready channel interfaces for frame commands and per-item results.
interface irft_item_if
  import irft_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [CodeW-1:0] code;

  modport source (output valid, output func, output code, input ready);
  modport sink   (input valid, input func, input code, output ready);
endinterface

interface irft_result_if;
  logic valid;
  logic ready;
  logic ir_out;
  logic mark_active;
  logic busy_res;
  logic frame_done;
  logic start_ignored;

  modport source (output valid, output ir_out, output mark_active, output busy_res,
                  output frame_done, output start_ignored, input ready);
  modport sink   (input valid, input ir_out, input mark_active, input busy_res,
                  input frame_done, input start_ignored, output ready);
endinterface

### hdl/ir_frame_transmitter.sv
// Infrared frame transmitter: takes one tick or start beat per cycle while
// results are taken and returns one result beat for each. An idle start beat
// loads a 32-bit code and begins a frame (leader mark and space, 32 bits MSB
// first as mark plus space, stop mark and stop space); each tick beat advances
// line time by one microsecond and reports the carrier-gated emitter drive. The
// frame sequencer updates in the cycle a beat is accepted and its result lands
// in an output register. A two-entry output buffer (output register plus skid
// register) lets it take a beat while a result still waits; ready drops only
// when both entries are full. The user must write registers via cfg_we, cfg_index
// and cfg_data only while no frame is in flight; the block does not enforce this.
module ir_frame_transmitter
  import irft_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  irft_item_if.sink           item,
  irft_result_if.source       result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [PeriodW-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_MARK,
    PH_LEAD_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_STOP_MARK,
    PH_STOP_SPACE
  } phase_t;

  logic [PeriodW-1:0] leader_mark_ticks;
  logic [PeriodW-1:0] leader_space_ticks;
  logic [PeriodW-1:0] bit_mark_ticks;
  logic [PeriodW-1:0] one_space_ticks;
  logic [PeriodW-1:0] zero_space_ticks;
  logic [PeriodW-1:0] stop_space_ticks;
  logic [HalfW-1:0]   carrier_half_ticks;

  phase_t              phase, phase_next;
  logic [PeriodW-1:0]  period_left, period_left_next;
  logic [CodeBits-1:0] shift_word, shift_word_next;
  logic [BitCntW-1:0]  bits_left, bits_left_next;
  logic [HalfW-1:0]    carrier_count, carrier_count_next;
  logic                carrier_level, carrier_level_next;

  result_t out_data, skid_data, res_next;
  logic    out_valid, skid_valid;

  logic               accept;
  logic               in_mark;
  logic [HalfW-1:0]   half;
  logic [HalfW-1:0]   count_inc;
  logic [PeriodW-1:0] period_dec;

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;

  assign in_mark    = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK) ||
                      (phase == PH_STOP_MARK);
  assign half       = (carrier_half_ticks == '0) ? HalfW'(1) : carrier_half_ticks;
  assign count_inc  = carrier_count + HalfW'(1);
  assign period_dec = (period_left == '0) ? '0 : period_left - PeriodW'(1);

  always_comb begin
    phase_next         = phase;
    period_left_next   = period_left;
    shift_word_next    = shift_word;
    bits_left_next     = bits_left;
    carrier_count_next = carrier_count;
    carrier_level_next = carrier_level;
    res_next           = '0;

    if (accept) begin
      if (item.func == FuncStart) begin
        res_next.busy_res = 1'b1;
        if (phase != PH_IDLE) begin
          res_next.start_ignored = 1'b1;
        end else begin
          shift_word_next    = CodeBits'(item.code);
          bits_left_next     = BitCntW'(CodeBits);
          phase_next         = PH_LEAD_MARK;
          period_left_next   = period_len(leader_mark_ticks);
          carrier_count_next = '0;
          carrier_level_next = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        res_next.busy_res = 1'b1;
        if (in_mark) begin
          res_next.mark_active = 1'b1;
          res_next.ir_out      = carrier_level;
          if (count_inc >= half) begin
            carrier_count_next = '0;
            carrier_level_next = !carrier_level;
          end else begin
            carrier_count_next = count_inc;
          end
        end
        period_left_next = period_dec;
        if (period_dec == '0) begin
          // Every phase change restarts the carrier: high for marks, low for spaces.
          carrier_count_next = '0;
          carrier_level_next = 1'b0;
          case (phase)
            PH_LEAD_MARK: begin
              phase_next       = PH_LEAD_SPACE;
              period_left_next = period_len(leader_space_ticks);
            end
            PH_LEAD_SPACE: begin
              phase_next         = PH_BIT_MARK;
              period_left_next   = period_len(bit_mark_ticks);
              carrier_level_next = 1'b1;
            end
            PH_BIT_MARK: begin
              shift_word_next  = shift_word << 1;
              bits_left_next   = (bits_left == '0) ? '0 : bits_left - BitCntW'(1);
              phase_next       = PH_BIT_SPACE;
              period_left_next = shift_word[CodeBits-1] ? period_len(one_space_ticks)
                                                        : period_len(zero_space_ticks);
            end
            PH_BIT_SPACE: begin
              phase_next         = (bits_left != '0) ? PH_BIT_MARK : PH_STOP_MARK;
              period_left_next   = period_len(bit_mark_ticks);
              carrier_level_next = 1'b1;
            end
            PH_STOP_MARK: begin
              phase_next       = PH_STOP_SPACE;
              period_left_next = period_len(stop_space_ticks);
            end
            default: begin
              phase_next          = PH_IDLE;
              period_left_next    = '0;
              res_next.frame_done = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_ticks  <= LeaderMarkReset;
      leader_space_ticks <= LeaderSpaceReset;
      bit_mark_ticks     <= BitMarkReset;
      one_space_ticks    <= OneSpaceReset;
      zero_space_ticks   <= ZeroSpaceReset;
      stop_space_ticks   <= StopSpaceReset;
      carrier_half_ticks <= CarrierHalfReset;
      phase              <= PH_IDLE;
      period_left        <= '0;
      shift_word         <= '0;
      bits_left          <= '0;
      carrier_count      <= '0;
      carrier_level      <= 1'b0;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEADER_MARK:  leader_mark_ticks  <= cfg_data;
          REG_LEADER_SPACE: leader_space_ticks <= cfg_data;
          REG_BIT_MARK:     bit_mark_ticks     <= cfg_data;
          REG_ONE_SPACE:    one_space_ticks    <= cfg_data;
          REG_ZERO_SPACE:   zero_space_ticks   <= cfg_data;
          REG_STOP_SPACE:   stop_space_ticks   <= cfg_data;
          REG_CARRIER_HALF: carrier_half_ticks <= cfg_data[HalfW-1:0];
          default: ;
        endcase
      end

      phase         <= phase_next;
      period_left   <= period_left_next;
      shift_word    <= shift_word_next;
      bits_left     <= bits_left_next;
      carrier_count <= carrier_count_next;
      carrier_level <= carrier_level_next;

      // The skid register only fills when the output register is stalled.
      if (!out_valid || result.ready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_data  <= res_next;
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_data  <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.ir_out        = out_data.ir_out;
  assign result.mark_active   = out_data.mark_active;
  assign result.busy_res      = out_data.busy_res;
  assign result.frame_done    = out_data.frame_done;
  assign result.start_ignored = out_data.start_ignored;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the infrared frame transmitter.
module tb_top;
  import irft_pkg::*;

  localparam int NumRegs = int'(REG_CARRIER_HALF) + 1;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 200_000;
  localparam int IdlePct = 19;
  localparam int MaxPrinted = 30;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 50;
  localparam logic [PeriodW-1:0] LongMark = 16'd300;
  localparam logic [PeriodW-1:0] LongLen = 16'd150;

  typedef enum logic [2:0] {
    PhIdle,
    PhLeadMark,
    PhLeadSpace,
    PhBitMark,
    PhBitSpace,
    PhStopMark,
    PhStopSpace
  } frame_phase_t;

  class frame_scoreboard;
    logic [PeriodW-1:0] regs [NumRegs];
    frame_phase_t phase;
    logic [PeriodW-1:0] remain;
    logic [CodeBits-1:0] shifter;
    int bits_to_go;
    logic [HalfW-1:0] carrier_cnt;
    logic carrier_lvl;
    result_t due_q [$];
    string field_name [5] = '{"start_ignored", "frame_done", "busy_res", "mark_active",
                              "ir_out"};
    int errors, checked, ticks, starts, dropped, frames;

    function new();
      regs[REG_LEADER_MARK]  = LeaderMarkReset;
      regs[REG_LEADER_SPACE] = LeaderSpaceReset;
      regs[REG_BIT_MARK]     = BitMarkReset;
      regs[REG_ONE_SPACE]    = OneSpaceReset;
      regs[REG_ZERO_SPACE]   = ZeroSpaceReset;
      regs[REG_STOP_SPACE]   = StopSpaceReset;
      regs[REG_CARRIER_HALF] = PeriodW'(CarrierHalfReset);
      phase = PhIdle;
      remain = '0;
      shifter = '0;
      bits_to_go = 0;
      carrier_cnt = '0;
      carrier_lvl = 1'b0;
    endfunction

    function void report(string msg);
      errors++;
      // Keep the log short when a broken block floods the checker.
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [PeriodW-1:0] val);
      if (idx == REG_CARRIER_HALF) regs[idx] = PeriodW'(val[HalfW-1:0]);
      else if (idx < NumRegs) regs[idx] = val;
    endfunction

    function bit in_frame();
      return phase != PhIdle;
    endfunction

    // Marks start with the carrier high, spaces with it low.
    function void enter_period(frame_phase_t ph, logic [PeriodW-1:0] len, logic lvl);
      phase = ph;
      remain = (len == '0) ? PeriodW'(1) : len;
      carrier_cnt = '0;
      carrier_lvl = lvl;
    endfunction

    function void note(logic f, logic [CodeW-1:0] c);
      result_t r;
      logic [HalfW-1:0] half;
      logic msb;
      r = '0;
      if (f == FuncStart) begin
        starts++;
        if (phase != PhIdle) begin
          r.start_ignored = 1'b1;
          dropped++;
        end else begin
          shifter = CodeBits'(c);
          bits_to_go = CodeBits;
          enter_period(PhLeadMark, regs[REG_LEADER_MARK], 1'b1);
        end
        r.busy_res = 1'b1;
      end else begin
        ticks++;
        if (phase != PhIdle) begin
          r.busy_res = 1'b1;
          if (phase inside {PhLeadMark, PhBitMark, PhStopMark}) begin
            half = regs[REG_CARRIER_HALF][HalfW-1:0];
            if (half == '0) half = HalfW'(1);
            r.mark_active = 1'b1;
            r.ir_out = carrier_lvl;
            carrier_cnt = carrier_cnt + 1'b1;
            if (carrier_cnt >= half) begin
              carrier_cnt = '0;
              carrier_lvl = ~carrier_lvl;
            end
          end
          if (remain != '0) remain = remain - 1'b1;
          if (remain == '0) begin
            case (phase)
              PhLeadMark: enter_period(PhLeadSpace, regs[REG_LEADER_SPACE], 1'b0);
              PhLeadSpace: enter_period(PhBitMark, regs[REG_BIT_MARK], 1'b1);
              PhBitMark: begin
                msb = shifter[CodeBits-1];
                shifter = shifter << 1;
                if (bits_to_go > 0) bits_to_go--;
                enter_period(PhBitSpace, msb ? regs[REG_ONE_SPACE] : regs[REG_ZERO_SPACE],
                             1'b0);
              end
              PhBitSpace: begin
                enter_period((bits_to_go > 0) ? PhBitMark : PhStopMark, regs[REG_BIT_MARK],
                             1'b1);
              end
              PhStopMark: enter_period(PhStopSpace, regs[REG_STOP_SPACE], 1'b0);
              default: begin
                phase = PhIdle;
                remain = '0;
                carrier_cnt = '0;
                carrier_lvl = 1'b0;
                r.frame_done = 1'b1;
                frames++;
              end
            endcase
          end
        end
      end
      due_q.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result %b arrived with nothing outstanding", got));
        return;
      end
      want = due_q.pop_front();
      for (int b = 0; b < $bits(result_t); b++) begin
        if (got[b] !== want[b])
          report($sformatf("result %0d: %s is %b, want %b", checked, field_name[b], got[b],
                           want[b]));
      end
      checked++;
    endfunction

    function void flush_leftover();
      while (due_q.size() != 0) begin
        report($sformatf("result %b never arrived", due_q.pop_front()));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [PeriodW-1:0] cfg_data;
  logic [PeriodW-1:0] next_regs [NumRegs];
  bit steady = 1'b0;
  int cycles = 0;
  int settings_done = 0;
  frame_scoreboard sb = new();

  irft_item_if item_ch ();
  irft_result_if result_ch ();

  ir_frame_transmitter i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles,
             sb.due_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Result side: check every beat taken, then choose the next ready level.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check(result_t'({result_ch.ir_out, result_ch.mark_active, result_ch.busy_res,
                          result_ch.frame_done, result_ch.start_ignored}));
    result_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  function automatic bit holds_off();
    return !steady && ($urandom_range(99) < IdlePct);
  endfunction

  function automatic logic [CodeW-1:0] pick_code();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return CodeW'(1) << $urandom_range(CodeW - 1);
      default: return CodeW'($urandom);
    endcase
  endfunction

  function automatic logic [PeriodW-1:0] short_len();
    case ($urandom_range(19))
      0: return '0;
      1: return PeriodW'($urandom_range(8, 24));
      default: return PeriodW'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [PeriodW-1:0] pick_half();
    case ($urandom_range(9))
      0: return '0;
      1: return PeriodW'(255);
      2: return PeriodW'($urandom);
      default: return PeriodW'($urandom_range(1, 4));
    endcase
  endfunction

  // Valid stays high from one beat to the next unless the sender idles.
  task automatic send_item(logic f, logic [CodeW-1:0] c);
    while (holds_off()) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= f;
    item_ch.code <= c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note(f, c);
  endtask

  task automatic tick();
    send_item(FuncTick, pick_code());
  endtask

  task automatic finish_frame();
    while (sb.in_frame()) tick();
  endtask

  task automatic quiesce();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_q.size() != 0);
  endtask

  task automatic program_regs(bit poke_unused);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= next_regs[i];
      @(posedge clk);
      sb.set_reg(3'(i), next_regs[i]);
    end
    // A write to an index past the last register must leave everything alone.
    if (poke_unused) begin
      cfg_index <= RegUnused;
      cfg_data <= PeriodW'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic run_random(int n);
    bit go_start;
    repeat (n) begin
      if (!sb.in_frame()) go_start = $urandom_range(99) < 30;
      else go_start = $urandom_range(199) == 0;
      if (go_start) send_item(FuncStart, pick_code());
      else tick();
      if ($urandom_range(999) == 0) quiesce();
    end
    finish_frame();
    quiesce();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.func <= FuncTick;
    item_ch.code <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Ticks with no frame running report nothing but zeros.
    tick();
    tick();
    quiesce();

    // Shortest legal periods and the fastest carrier.
    foreach (next_regs[i]) next_regs[i] = PeriodW'(1);
    program_regs(1'b0);
    tick();
    send_item(FuncStart, '1);
    send_item(FuncStart, '0);
    tick();
    finish_frame();
    send_item(FuncStart, '0);
    finish_frame();
    quiesce();

    // Zero in every register must behave as a length of one.
    foreach (next_regs[i]) next_regs[i] = '0;
    program_regs(1'b1);
    send_item(FuncStart, 32'hA5C3_0F96);
    tick();
    send_item(FuncStart, '1);
    finish_frame();
    quiesce();

    for (int p = 0; p < RandomPhases; p++) begin
      foreach (next_regs[i]) next_regs[i] = short_len();
      next_regs[REG_CARRIER_HALF] = pick_half();
      program_regs(p % 3 == 0);
      run_random(ItemsPerPhase);
    end

    // Long leader mark, one space and stop space, slowest carrier, no idling.
    steady = 1'b1;
    foreach (next_regs[i]) next_regs[i] = PeriodW'(2);
    next_regs[REG_LEADER_MARK] = LongMark;
    next_regs[REG_ONE_SPACE] = LongLen;
    next_regs[REG_STOP_SPACE] = LongLen;
    next_regs[REG_CARRIER_HALF] = PeriodW'(255);
    program_regs(1'b0);
    send_item(FuncStart, 32'h0000_0001);
    finish_frame();
    quiesce();
    steady = 1'b0;

    // Long leader space and zero space, on a code with a single zero bit.
    foreach (next_regs[i]) next_regs[i] = PeriodW'(1);
    next_regs[REG_LEADER_SPACE] = LongLen;
    next_regs[REG_ZERO_SPACE] = LongLen;
    program_regs(1'b0);
    send_item(FuncStart, 32'hFFFF_FFFE);
    finish_frame();
    quiesce();

    // Anything still coming out now is a spurious beat.
    repeat (20) @(posedge clk);
    sb.flush_leftover();

    $display("Covered %0d frames sent, %0d starts dropped while busy, %0d ticks",
             sb.frames, sb.dropped, sb.ticks);
    $display("Checked %0d results over %0d register settings, %0d mismatches",
             sb.checked, settings_done, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/irft_pkg.sv
hdl/irft_if.sv
hdl/ir_frame_transmitter.sv
test/tb_top.sv
